@@ rtl/core/slot_pool_evict_oldest_defines.svh @@
// Assertion macros shared by the pool logic.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef SLOT_POOL_EVICT_OLDEST_DEFINES_SVH
`define SLOT_POOL_EVICT_OLDEST_DEFINES_SVH

// The consequence must hold in the same cycle as the antecedent.
`define SPEO_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define SPEO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/speo_pkg.sv @@
`default_nettype none

package speo_pkg;

    localparam int unsigned MAX_SLOTS_DEF  = 64;
    localparam int unsigned OWNER_BITS_DEF = 16;
    localparam int unsigned CAPACITY_RESET = 10;

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_ALLOC   = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_LOAD,
        CELL_INIT
    } cell_op_t;

    typedef struct packed {
        logic clr;
        logic rm;
        logic ap;
    } qop_t;

endpackage

`default_nettype wire

@@ rtl/core/speo_cell.sv @@
`default_nettype none

module speo_cell
    import speo_pkg::*;
#(
    parameter int unsigned W = 8,
    parameter logic [W-1:0] INIT_VAL = '0
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cell_op_t     op,
    input  wire logic [W-1:0] up_data,
    input  wire logic [W-1:0] load_data,
    output logic      [W-1:0] q
);

    logic [W-1:0] data_reg;
    logic [W-1:0] data_next;

    always_comb
    begin
        case (op)
            CELL_SHIFT: data_next = up_data;
            CELL_LOAD:  data_next = load_data;
            CELL_INIT:  data_next = INIT_VAL;
            default:    data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= INIT_VAL;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign q = data_reg;

endmodule

`default_nettype wire

@@ rtl/core/speo_queue.sv @@
`default_nettype none

module speo_queue
    import speo_pkg::*;
#(
    parameter int unsigned DEPTH     = MAX_SLOTS_DEF,
    parameter int unsigned W         = 8,
    parameter int unsigned RST_COUNT = 0,
    localparam int unsigned IDX_W    = $clog2(DEPTH),
    localparam int unsigned CNT_W    = $clog2(DEPTH + 1)
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire qop_t                       qop,
    input  wire logic [IDX_W-1:0]           rm_pos,
    input  wire logic [W-1:0]               ap_data,
    input  wire logic [CNT_W-1:0]           clr_count,
    output logic      [DEPTH-1:0][W-1:0]    entries,
    output logic      [CNT_W-1:0]           count
);

    // Removing an entry shifts every younger entry one cell toward the head;
    // an appended entry lands at the tail after that shift.
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] tail;

    assign tail = cnt_reg - CNT_W'(qop.rm);

    always_comb
    begin
        if (qop.clr)
        begin
            cnt_next = clr_count;
        end
        else
        begin
            cnt_next = cnt_reg - CNT_W'(qop.rm) + CNT_W'(qop.ap);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CNT_W'(RST_COUNT);
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign count = cnt_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_op_t     op;
        logic [W-1:0] up;

        if (i < DEPTH - 1)
        begin : g_up
            assign up = entries[i+1];
        end
        else
        begin : g_top
            assign up = entries[i];
        end

        always_comb
        begin
            if (qop.clr)
            begin
                op = CELL_INIT;
            end
            else if (qop.ap && (tail == CNT_W'(i)))
            begin
                op = CELL_LOAD;
            end
            else if (qop.rm && (IDX_W'(i) >= rm_pos))
            begin
                op = CELL_SHIFT;
            end
            else
            begin
                op = CELL_HOLD;
            end
        end

        speo_cell #(
            .W        (W),
            .INIT_VAL (W'(i))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .op        (op),
            .up_data   (up),
            .load_data (ap_data),
            .q         (entries[i])
        );
    end

endmodule

`default_nettype wire

@@ rtl/core/slot_pool_evict_oldest.sv @@
// Channel   Direction  Contents
// s_axis    in         tdata: owner_id, slot_in; tuser: command, has_slot
// m_axis    out        tdata: slot_out, evicted_owner; tuser: evicted, status
// cfg       in         pool_capacity, written when cfg_wr_en is high
//
// The whole update of both cell chains and the result register happens at the edge
// that accepts a transaction, so s_axis_tready stays high while the result register
// is empty or being drained in the same cycle.
// Reset leaves the pool as after a clear with capacity ten and no slot taken.
// A stalled result holds the input off; nothing else stalls the block.
`default_nettype none

`include "slot_pool_evict_oldest_defines.svh"

module slot_pool_evict_oldest
    import speo_pkg::*;
#(
    parameter int unsigned MAX_SLOTS  = MAX_SLOTS_DEF,
    parameter int unsigned OWNER_BITS = OWNER_BITS_DEF,
    localparam int unsigned SW     = $clog2(MAX_SLOTS),
    localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1),
    localparam int unsigned DATA_W = ((OWNER_BITS + SW + 7) / 8) * 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [DATA_W-1:0] s_axis_tdata,  // owner_id, slot_in, zero fill
    input  wire logic [2:0]        s_axis_tuser,  // command, has_slot
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [DATA_W-1:0] m_axis_tdata,  // slot_out, evicted_owner, zero fill
    output logic      [1:0]        m_axis_tuser,  // evicted, status
    input  wire logic              cfg_wr_en,
    input  wire logic [CNT_W-1:0]  cfg_wr_data
);

    localparam int unsigned TW       = OWNER_BITS + SW;
    localparam int unsigned CNT_MAX  = (1 << CNT_W) - 1;
    localparam int unsigned CAP_RST  = (CAPACITY_RESET > CNT_MAX) ? CNT_MAX : CAPACITY_RESET;
    localparam int unsigned FREE_RST = (CAPACITY_RESET > MAX_SLOTS) ? MAX_SLOTS : CAPACITY_RESET;

    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] cap_sat;

    logic                  accept;
    logic [1:0]            cmd;
    logic [OWNER_BITS-1:0] owner;
    logic [SW-1:0]         slot;
    logic                  has;

    logic [MAX_SLOTS-1:0][TW-1:0] taken_q;
    logic [MAX_SLOTS-1:0][SW-1:0] free_q;
    logic [CNT_W-1:0]             taken_cnt;
    logic [CNT_W-1:0]             free_cnt;

    logic [MAX_SLOTS-1:0] match;
    logic [SW-1:0]        rel_pos;
    logic                 in_pool;
    logic                 evict;
    logic                 grant;
    logic                 rel_ok;
    logic [SW-1:0]        grant_slot;
    logic [SW-1:0]        oldest_slot;
    logic [OWNER_BITS-1:0] oldest_owner;

    qop_t             taken_op;
    qop_t             free_op;
    logic [SW-1:0]    taken_rm_pos;

    logic [SW-1:0]         res_slot;
    logic [OWNER_BITS-1:0] res_owner;
    logic                  res_status;

    logic              m_valid_reg;
    logic [DATA_W-1:0] m_data_reg;
    logic [1:0]        m_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CNT_W'(CAP_RST);
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_sat = CNT_W'(1);
        end
        else if (cap_reg > CNT_W'(MAX_SLOTS))
        begin
            cap_sat = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            cap_sat = cap_reg;
        end
    end

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign cmd   = s_axis_tuser[1:0];
    assign has   = s_axis_tuser[2];
    assign owner = s_axis_tdata[OWNER_BITS-1:0];
    assign slot  = s_axis_tdata[OWNER_BITS +: SW];

    assign oldest_slot  = taken_q[0][SW-1:0];
    assign oldest_owner = taken_q[0][TW-1:SW];

    // Taken slots sit in age order, and a slot appears in at most one live cell.
    always_comb
    begin
        match   = '0;
        rel_pos = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            if ((CNT_W'(i) < taken_cnt) && (taken_q[i][SW-1:0] == slot))
            begin
                match[i] = 1'b1;
            end
        end
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            if (match[i])
            begin
                rel_pos = rel_pos | SW'(i);
            end
        end
    end

    assign in_pool    = {1'b0, slot} < (SW+1)'(MAX_SLOTS);
    assign evict      = (cmd == CMD_ALLOC) && (free_cnt == '0) && (taken_cnt != '0);
    assign grant      = (cmd == CMD_ALLOC) && ((free_cnt != '0) || (taken_cnt != '0));
    assign rel_ok     = (cmd == CMD_RELEASE) && has && in_pool && (match != '0);
    assign grant_slot = evict ? oldest_slot : free_q[0];

    always_comb
    begin
        taken_op.clr = accept && (cmd == CMD_CLEAR);
        taken_op.rm  = accept && (evict || rel_ok);
        taken_op.ap  = accept && grant;
        free_op.clr  = accept && (cmd == CMD_CLEAR);
        free_op.rm   = accept && grant && !evict;
        free_op.ap   = accept && rel_ok;
        taken_rm_pos = evict ? '0 : rel_pos;
    end

    speo_queue #(
        .DEPTH     (MAX_SLOTS),
        .W         (TW),
        .RST_COUNT (0)
    ) u_taken (
        .clk       (clk),
        .rst_n     (rst_n),
        .qop       (taken_op),
        .rm_pos    (taken_rm_pos),
        .ap_data   ({owner, grant_slot}),
        .clr_count ('0),
        .entries   (taken_q),
        .count     (taken_cnt)
    );

    speo_queue #(
        .DEPTH     (MAX_SLOTS),
        .W         (SW),
        .RST_COUNT (FREE_RST)
    ) u_free (
        .clk       (clk),
        .rst_n     (rst_n),
        .qop       (free_op),
        .rm_pos    ('0),
        .ap_data   (slot),
        .clr_count (cap_sat),
        .entries   (free_q),
        .count     (free_cnt)
    );

    always_comb
    begin
        if (grant)
        begin
            res_slot = grant_slot;
        end
        else if (rel_ok)
        begin
            res_slot = slot;
        end
        else
        begin
            res_slot = '0;
        end
        res_owner  = evict ? oldest_owner : '0;
        res_status = (cmd == CMD_RELEASE) && !rel_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_data_reg <= DATA_W'({res_owner, res_slot});
            m_user_reg <= {res_status, evict};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    `SPEO_ASSERT_SAME(a_slots_bounded, 1'b1,
        ((CNT_W+1)'(free_cnt) + (CNT_W+1)'(taken_cnt) <= (CNT_W+1)'(MAX_SLOTS)),
        "free and taken slots exceed the pool")
    `SPEO_ASSERT_SAME(a_pool_not_empty, 1'b1, (free_cnt != '0) || (taken_cnt != '0),
        "pool holds neither free nor taken slots")
    `SPEO_ASSERT_SAME(a_unique_taken, 1'b1, $onehot0(match),
        "a slot is taken twice")
    `SPEO_ASSERT_NEXT(a_result_follows, accept, m_axis_tvalid,
        "accepted transaction left no result")
    `SPEO_ASSERT_NEXT(a_grant_taken, accept && grant, taken_cnt != '0,
        "granted slot missing from the taken chain")

endmodule

`default_nettype wire
